>>> design/window_convolution_3x3_defines.svh
// Assertion macros for the window convolution RTL.
`ifndef WINDOW_CONVOLUTION_3X3_DEFINES_SVH
`define WINDOW_CONVOLUTION_3X3_DEFINES_SVH

`ifndef SYNTH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define WC3_ASSERT_IMPLY(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("window_convolution_3x3: implication check failed");

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define WC3_ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("window_convolution_3x3: next-cycle check failed");

`else

`define WC3_ASSERT_IMPLY(lbl, pre, post)
`define WC3_ASSERT_NEXT(lbl, pre, post)

`endif

`endif

>>> design/wc3_pkg.sv
// Types, constants and helper functions for the 3x3 window convolution.
`default_nettype none

package wc3_pkg;

    localparam int PIXEL_BITS    = 16;
    localparam int LINE_DEPTH    = 256;
    localparam int ADDR_BITS     = $clog2(LINE_DEPTH);
    localparam int COORD_BITS    = 8;
    localparam int SIZE_BITS     = 9;
    localparam int COEF_BITS     = 16;
    localparam int KROW_BITS     = 3 * COEF_BITS;
    localparam int CFG_DATA_BITS = KROW_BITS;
    localparam int CFG_IDX_BITS  = 3;
    localparam int MARGIN_BITS   = 2;
    localparam int PROD_BITS     = PIXEL_BITS + 1 + COEF_BITS;
    localparam int ROW_SUM_BITS  = PROD_BITS + 2;
    localparam int SUM_BITS      = PROD_BITS + 3;
    localparam int RESULT_BITS   = 16;
    localparam int BLUR_SHIFT    = 4;

    localparam logic [SIZE_BITS-1:0]   MIN_SIZE   = SIZE_BITS'(3);
    localparam logic [SIZE_BITS-1:0]   MAX_WIDTH  = SIZE_BITS'(256);
    localparam logic [SIZE_BITS-1:0]   MAX_HEIGHT = SIZE_BITS'(256);
    localparam logic [RESULT_BITS-1:0] BLUR_MAX   = RESULT_BITS'(16'h3fff);

    // Reset kernel is Sobel-x: {-1,0,1}, {-2,0,2}, {-1,0,1}, left column in the low bits.
    localparam logic [KROW_BITS-1:0] KROW_TOP_RESET = 48'h0000_0001_0000_ffff;
    localparam logic [KROW_BITS-1:0] KROW_MID_RESET = 48'h0000_0002_0000_fffe;
    localparam logic [KROW_BITS-1:0] KROW_BOT_RESET = 48'h0000_0001_0000_ffff;
    localparam logic [MARGIN_BITS-1:0] MARGIN_RESET = MARGIN_BITS'(2);
    localparam logic [SIZE_BITS-1:0]   WIDTH_RESET  = SIZE_BITS'(160);
    localparam logic [SIZE_BITS-1:0]   HEIGHT_RESET = SIZE_BITS'(120);

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_KERNEL_TOP    = 3'd0,
        CFG_KERNEL_MID    = 3'd1,
        CFG_KERNEL_BOTTOM = 3'd2,
        CFG_MODE          = 3'd3,
        CFG_BORDER_MARGIN = 3'd4,
        CFG_IMAGE_WIDTH   = 3'd5,
        CFG_IMAGE_HEIGHT  = 3'd6
    } cfg_index_t;

    typedef enum logic {
        MODE_EDGE = 1'b0,
        MODE_BLUR = 1'b1
    } filter_mode_t;

    typedef struct packed {
        logic [PIXEL_BITS-1:0] pixel_in;
        logic                  frame_start;
    } pixel_t;

    typedef struct packed {
        logic [RESULT_BITS-1:0] result_value;
        logic [COORD_BITS-1:0]  centre_row;
        logic [COORD_BITS-1:0]  centre_col;
        logic                   computed;
        logic                   frame_last;
    } result_t;

    function automatic logic [SIZE_BITS-1:0] clamp_size(
        input logic [SIZE_BITS-1:0] v,
        input logic [SIZE_BITS-1:0] maxv
    );
        logic [SIZE_BITS-1:0] r;
        if (v < MIN_SIZE)
            r = MIN_SIZE;
        else if (v > maxv)
            r = maxv;
        else
            r = v;
        return r;
    endfunction

    function automatic logic signed [COEF_BITS-1:0] coef_of(
        input logic [KROW_BITS-1:0] krow,
        input int                   idx
    );
        return $signed(krow[idx*COEF_BITS +: COEF_BITS]);
    endfunction

endpackage

`default_nettype wire

>>> design/window_convolution_3x3.sv
// Streaming 3x3 convolution over a raster-order frame with two line memories.
//
// Pixels enter on the pixel channel (valid/ready), one item per clock when the
// result side keeps up. Every pixel with row >= 2 and column >= 2 produces one
// item on the result channel, for the window centred one row up and one column
// left; earlier pixels of each row and the first two rows produce nothing.
// The rate is one pixel per cycle while the result side keeps up, set by the single
// read-modify-write of the line memories per pixel; a back-to-back access to the same
// column is forwarded. frame_start on a pixel restarts the row and column counters at zero.
// Configuration is written through cfg_write_en / cfg_index / cfg_data while the block is
// idle, a rule the user must keep, as the block itself does not enforce it; indexes beyond
// the list are ignored.
// Reset (rst_n, asynchronous, active low) restores the Sobel-x kernel, edge mode,
// margin 2 and a 160 x 120 frame, clears the window and the counters. The line
// memories are not cleared: each entry is written in the first row of a frame.
// When the receiver stalls, the whole pipeline holds and pixel_ready drops, so
// no item is lost; pixel_ready stays high while the output register is free.
`default_nettype none

`include "window_convolution_3x3_defines.svh"

module window_convolution_3x3
    import wc3_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     pixel_valid,
    output logic                     pixel_ready,
    input  pixel_t                   pixel,
    output logic                     result_valid,
    input  logic                     result_ready,
    output result_t                  result,
    input  logic                     cfg_write_en,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data
);

    // Configuration registers.
    logic [KROW_BITS-1:0]   krow_top_reg;
    logic [KROW_BITS-1:0]   krow_mid_reg;
    logic [KROW_BITS-1:0]   krow_bot_reg;
    filter_mode_t           mode_reg;
    logic [MARGIN_BITS-1:0] margin_reg;
    logic [SIZE_BITS-1:0]   width_reg;
    logic [SIZE_BITS-1:0]   height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            krow_top_reg <= KROW_TOP_RESET;
            krow_mid_reg <= KROW_MID_RESET;
            krow_bot_reg <= KROW_BOT_RESET;
            mode_reg     <= MODE_EDGE;
            margin_reg   <= MARGIN_RESET;
            width_reg    <= WIDTH_RESET;
            height_reg   <= HEIGHT_RESET;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                CFG_KERNEL_TOP:    krow_top_reg <= cfg_data[KROW_BITS-1:0];
                CFG_KERNEL_MID:    krow_mid_reg <= cfg_data[KROW_BITS-1:0];
                CFG_KERNEL_BOTTOM: krow_bot_reg <= cfg_data[KROW_BITS-1:0];
                CFG_MODE:          mode_reg     <= filter_mode_t'(cfg_data[0]);
                CFG_BORDER_MARGIN: margin_reg   <= cfg_data[MARGIN_BITS-1:0];
                CFG_IMAGE_WIDTH:   width_reg    <= cfg_data[SIZE_BITS-1:0];
                CFG_IMAGE_HEIGHT:  height_reg   <= cfg_data[SIZE_BITS-1:0];
                default:           ;
            endcase
        end
    end

    logic [SIZE_BITS-1:0] w_size;
    logic [SIZE_BITS-1:0] h_size;
    logic [SIZE_BITS-1:0] w_m1;
    logic [SIZE_BITS-1:0] h_m1;
    logic [SIZE_BITS-1:0] w_m2;

    assign w_size = clamp_size(width_reg, MAX_WIDTH);
    assign h_size = clamp_size(height_reg, MAX_HEIGHT);
    assign w_m1   = w_size - SIZE_BITS'(1);
    assign h_m1   = h_size - SIZE_BITS'(1);
    assign w_m2   = w_size - SIZE_BITS'(2);

    // Pipeline control: every stage moves together whenever the output register can take data.
    logic advance;
    logic accept;
    logic res_valid_reg;

    assign advance     = !res_valid_reg || result_ready;
    assign pixel_ready = advance;
    assign accept      = pixel_valid && advance;

    // Stage 0: position of the incoming pixel and its result bookkeeping.
    logic [COORD_BITS-1:0] row_count_reg;
    logic [COORD_BITS-1:0] col_count_reg;
    logic [COORD_BITS-1:0] row_cur;
    logic [COORD_BITS-1:0] col_cur;
    logic [SIZE_BITS-1:0]  col_inc;
    logic [SIZE_BITS-1:0]  row_inc;
    logic [COORD_BITS-1:0] row_count_next;
    logic [COORD_BITS-1:0] col_count_next;
    logic [COORD_BITS-1:0] cr_cur;
    logic [COORD_BITS-1:0] cc_cur;
    logic                  produce_cur;
    logic                  inside_cur;
    logic                  last_cur;
    logic [SIZE_BITS:0]    cr_ext;
    logic [SIZE_BITS:0]    cc_ext;
    logic [SIZE_BITS:0]    m_ext;

    always_comb
    begin
        row_cur = pixel.frame_start ? '0 : row_count_reg;
        col_cur = pixel.frame_start ? '0 : col_count_reg;
        col_inc = {1'b0, col_cur} + SIZE_BITS'(1);
        row_inc = {1'b0, row_cur} + SIZE_BITS'(1);
        if (col_inc >= w_size)
        begin
            col_count_next = '0;
            row_count_next = (row_inc >= h_size) ? '0 : row_inc[COORD_BITS-1:0];
        end
        else
        begin
            col_count_next = col_inc[COORD_BITS-1:0];
            row_count_next = row_cur;
        end
        produce_cur = (row_cur >= COORD_BITS'(2)) && (col_cur >= COORD_BITS'(2));
        cr_cur      = row_cur - COORD_BITS'(1);
        cc_cur      = col_cur - COORD_BITS'(1);
        cr_ext      = {2'b00, cr_cur};
        cc_ext      = {2'b00, cc_cur};
        m_ext       = {{(SIZE_BITS+1-MARGIN_BITS){1'b0}}, margin_reg};
        inside_cur  = (cr_ext >= m_ext) && (cc_ext >= m_ext)
                   && (cr_ext + m_ext <= {1'b0, h_m1})
                   && (cc_ext + m_ext <= {1'b0, w_m1});
        last_cur    = ({1'b0, row_cur} == h_m1) && ({1'b0, col_cur} == w_m1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg <= '0;
            col_count_reg <= '0;
        end
        else if (accept)
        begin
            row_count_reg <= row_count_next;
            col_count_reg <= col_count_next;
        end
    end

    // Stage 1: line memory read data arrives; window shift and write-back happen here.
    logic                  s1_valid_reg;
    logic [ADDR_BITS-1:0]  s1_addr_reg;
    logic [PIXEL_BITS-1:0] s1_pix_reg;
    logic                  s1_produce_reg;
    logic [COORD_BITS-1:0] s1_cr_reg;
    logic [COORD_BITS-1:0] s1_cc_reg;
    logic                  s1_inside_reg;
    logic                  s1_last_reg;
    logic                  bypass_reg;
    logic [PIXEL_BITS-1:0] byp_a_reg;
    logic [PIXEL_BITS-1:0] byp_b_reg;
    logic [PIXEL_BITS-1:0] rd_a_reg;
    logic [PIXEL_BITS-1:0] rd_b_reg;
    logic [PIXEL_BITS-1:0] a_cur;
    logic [PIXEL_BITS-1:0] b_cur;
    logic                  s1_write;

    logic [PIXEL_BITS-1:0] line_a_mem [LINE_DEPTH];
    logic [PIXEL_BITS-1:0] line_b_mem [LINE_DEPTH];

    // The item in stage 1 writes the same edge the next item reads, so a hit is forwarded.
    assign a_cur    = bypass_reg ? byp_a_reg : rd_a_reg;
    assign b_cur    = bypass_reg ? byp_b_reg : rd_b_reg;
    assign s1_write = advance && s1_valid_reg;

    always_ff @(posedge clk)
    begin
        if (s1_write)
            line_a_mem[s1_addr_reg] <= s1_pix_reg;
        if (advance)
            rd_a_reg <= line_a_mem[col_cur[ADDR_BITS-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (s1_write)
            line_b_mem[s1_addr_reg] <= a_cur;
        if (advance)
            rd_b_reg <= line_b_mem[col_cur[ADDR_BITS-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            bypass_reg   <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg <= accept;
            bypass_reg   <= s1_valid_reg && (s1_addr_reg == col_cur[ADDR_BITS-1:0]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_addr_reg    <= col_cur[ADDR_BITS-1:0];
            s1_pix_reg     <= pixel.pixel_in;
            s1_produce_reg <= produce_cur;
            s1_cr_reg      <= cr_cur;
            s1_cc_reg      <= cc_cur;
            s1_inside_reg  <= inside_cur;
            s1_last_reg    <= last_cur;
            byp_a_reg      <= s1_pix_reg;
            byp_b_reg      <= a_cur;
        end
    end

    // Window: index r*3+k, row 0 oldest line, column 2 newest.
    logic [PIXEL_BITS-1:0] window_reg  [9];
    logic [PIXEL_BITS-1:0] window_next [9];
    logic [KROW_BITS-1:0]  krow [3];

    assign krow[0] = krow_top_reg;
    assign krow[1] = krow_mid_reg;
    assign krow[2] = krow_bot_reg;

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            window_next[r*3]     = window_reg[r*3+1];
            window_next[r*3 + 1] = window_reg[r*3+2];
        end
        window_next[2] = b_cur;
        window_next[5] = a_cur;
        window_next[8] = s1_pix_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 9; i++)
                window_reg[i] <= '0;
        end
        else if (s1_write)
        begin
            for (int i = 0; i < 9; i++)
                window_reg[i] <= window_next[i];
        end
    end

    // Stage 2: nine products, one multiplier per tap.
    logic                        s2_valid_reg;
    logic [COORD_BITS-1:0]       s2_cr_reg;
    logic [COORD_BITS-1:0]       s2_cc_reg;
    logic                        s2_inside_reg;
    logic                        s2_last_reg;
    logic signed [PROD_BITS-1:0] prod_reg [9];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else if (advance)
            s2_valid_reg <= s1_valid_reg && s1_produce_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s2_cr_reg     <= s1_cr_reg;
            s2_cc_reg     <= s1_cc_reg;
            s2_inside_reg <= s1_inside_reg;
            s2_last_reg   <= s1_last_reg;
            for (int r = 0; r < 3; r++)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    prod_reg[r*3+k] <= PROD_BITS'($signed({1'b0, window_next[r*3+k]})
                                                  * coef_of(krow[r], k));
                end
            end
        end
    end

    // Stage 3: one sum per kernel row.
    logic                           s3_valid_reg;
    logic [COORD_BITS-1:0]          s3_cr_reg;
    logic [COORD_BITS-1:0]          s3_cc_reg;
    logic                           s3_inside_reg;
    logic                           s3_last_reg;
    logic signed [ROW_SUM_BITS-1:0] row_sum_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s3_valid_reg <= 1'b0;
        else if (advance)
            s3_valid_reg <= s2_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s3_cr_reg     <= s2_cr_reg;
            s3_cc_reg     <= s2_cc_reg;
            s3_inside_reg <= s2_inside_reg;
            s3_last_reg   <= s2_last_reg;
            for (int r = 0; r < 3; r++)
            begin
                row_sum_reg[r] <= ROW_SUM_BITS'(prod_reg[r*3])
                                + ROW_SUM_BITS'(prod_reg[r*3+1])
                                + ROW_SUM_BITS'(prod_reg[r*3+2]);
            end
        end
    end

    // Stage 4: total, then the absolute value of the 16-bit wrap or the clamped blur, or zero outside the margin.
    logic signed [SUM_BITS-1:0]      total;
    logic [RESULT_BITS-1:0]          low_bits;
    logic [RESULT_BITS-1:0]          edge_value;
    logic [SUM_BITS-BLUR_SHIFT-1:0]  shifted;
    logic [RESULT_BITS-1:0]          blur_value;
    logic [RESULT_BITS-1:0]          value_next;
    result_t                         res_reg;

    always_comb
    begin
        total      = SUM_BITS'(row_sum_reg[0]) + SUM_BITS'(row_sum_reg[1])
                   + SUM_BITS'(row_sum_reg[2]);
        low_bits   = total[RESULT_BITS-1:0];
        edge_value = low_bits[RESULT_BITS-1] ? (~low_bits + RESULT_BITS'(1)) : low_bits;
        shifted    = total[SUM_BITS-1:BLUR_SHIFT];
        if (total[SUM_BITS-1])
            blur_value = '0;
        else if (shifted > (SUM_BITS-BLUR_SHIFT)'(BLUR_MAX))
            blur_value = BLUR_MAX;
        else
            blur_value = shifted[RESULT_BITS-1:0];
        if (!s3_inside_reg)
            value_next = '0;
        else if (mode_reg == MODE_BLUR)
            value_next = blur_value;
        else
            value_next = edge_value;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (advance)
            res_valid_reg <= s3_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg.result_value <= value_next;
            res_reg.centre_row   <= s3_cr_reg;
            res_reg.centre_col   <= s3_cc_reg;
            res_reg.computed     <= s3_inside_reg;
            res_reg.frame_last   <= s3_last_reg;
        end
    end

    assign result_valid = res_valid_reg;
    assign result       = res_reg;

    `WC3_ASSERT_IMPLY(a_uncomputed_zero, result_valid && !result.computed, result.result_value == '0)
    `WC3_ASSERT_IMPLY(a_blur_bounded, result_valid && (mode_reg == MODE_BLUR), result.result_value <= BLUR_MAX)
    `WC3_ASSERT_IMPLY(a_last_position, result_valid && result.frame_last, result.centre_col == w_m2[COORD_BITS-1:0])
    `WC3_ASSERT_NEXT(a_frame_restart, accept && pixel.frame_start, (row_count_reg == '0) && (col_count_reg == COORD_BITS'(1)))

endmodule

`default_nettype wire

>>> bench/window_convolution_3x3_checker.sv
// Checker for the 3x3 window convolution: mirrors its line stores and window, predicts and compares results.
`timescale 1ns / 1ps

module window_convolution_3x3_checker
    import wc3_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     pixel_valid,
    input  logic                     pixel_ready,
    input  pixel_t                   pixel,
    input  logic                     result_valid,
    input  logic                     result_ready,
    input  result_t                  result,
    input  logic                     cfg_write_en,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data,
    output int                       open_results,
    output int                       mismatches
);

    localparam int LINE_LEN     = 256;
    localparam int BLUR_CEILING = 16383;

    logic [KROW_BITS-1:0]   kernel_rows [3];
    filter_mode_t           filter_mode;
    logic [MARGIN_BITS-1:0] margin;
    logic [SIZE_BITS-1:0]   width_reg;
    logic [SIZE_BITS-1:0]   height_reg;
    logic [PIXEL_BITS-1:0]  row_above [LINE_LEN];
    logic [PIXEL_BITS-1:0]  row_above2 [LINE_LEN];
    logic [PIXEL_BITS-1:0]  window [9];
    int                     next_row;
    int                     next_col;
    result_t                centre_results [$];

    function automatic int fit_size(input logic [SIZE_BITS-1:0] v);
        if (v < 3)
            return 3;
        if (v > LINE_LEN)
            return LINE_LEN;
        return int'(v);
    endfunction

    // Shifts one pixel into the window and line stores; returns 1 when a centre is complete.
    function automatic bit convolve_pixel(input pixel_t px, output result_t res);
        int                     w;
        int                     h;
        int                     row;
        int                     col;
        int                     c;
        int                     cr;
        int                     cc;
        int                     m;
        bit                     in_margin;
        longint                 acc;
        logic [15:0]            low;
        logic [RESULT_BITS-1:0] value;
        w = fit_size(width_reg);
        h = fit_size(height_reg);
        res = '0;
        if (px.frame_start)
        begin
            next_row = 0;
            next_col = 0;
        end
        row = next_row;
        col = next_col;
        c = col % LINE_LEN;
        for (int r = 0; r < 3; r++)
        begin
            window[r*3]     = window[r*3 + 1];
            window[r*3 + 1] = window[r*3 + 2];
        end
        window[2] = row_above2[c];
        window[5] = row_above[c];
        window[8] = px.pixel_in;
        row_above2[c] = row_above[c];
        row_above[c]  = px.pixel_in;

        // A counter left beyond a reduced size simply wraps at this advance.
        next_row = row;
        next_col = col + 1;
        if (next_col >= w)
        begin
            next_col = 0;
            next_row = row + 1;
            if (next_row >= h)
                next_row = 0;
        end

        if (row < 2 || col < 2)
            return 1'b0;

        cr = row - 1;
        cc = col - 1;
        m  = int'(margin);
        in_margin = cr >= m && cc >= m && cr + m <= h - 1 && cc + m <= w - 1;
        value = '0;
        if (in_margin)
        begin
            acc = 0;
            for (int r = 0; r < 3; r++)
                for (int k = 0; k < 3; k++)
                    acc += longint'(window[r*3 + k]) *
                           longint'($signed(kernel_rows[r][k*COEF_BITS +: COEF_BITS]));
            low = 16'(acc);
            if (filter_mode == MODE_EDGE)
                value = low[15] ? 16'(~low + 16'd1) : low;
            else if (acc < 0)
                value = '0;
            else if ((acc >>> 4) > BLUR_CEILING)
                value = RESULT_BITS'(BLUR_CEILING);
            else
                value = RESULT_BITS'(acc >>> 4);
        end
        res.result_value = value;
        res.centre_row   = 8'(cr);
        res.centre_col   = 8'(cc);
        res.computed     = in_margin;
        res.frame_last   = (row == h - 1 && col == w - 1);
        return 1'b1;
    endfunction

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge clk)
    begin
        result_t fresh;
        result_t want;
        if (!rst_n)
        begin
            kernel_rows[0] = 48'h0000_0001_0000_ffff;
            kernel_rows[1] = 48'h0000_0002_0000_fffe;
            kernel_rows[2] = 48'h0000_0001_0000_ffff;
            filter_mode    = MODE_EDGE;
            margin         = 2'd2;
            width_reg      = 9'd160;
            height_reg     = 9'd120;
            for (int i = 0; i < LINE_LEN; i++)
            begin
                row_above[i]  = '0;
                row_above2[i] = '0;
            end
            for (int i = 0; i < 9; i++)
                window[i] = '0;
            next_row = 0;
            next_col = 0;
            centre_results.delete();
        end
        else
        begin
            if (cfg_write_en)
            begin
                case (cfg_index_t'(cfg_index))
                    CFG_KERNEL_TOP:    kernel_rows[0] = cfg_data;
                    CFG_KERNEL_MID:    kernel_rows[1] = cfg_data;
                    CFG_KERNEL_BOTTOM: kernel_rows[2] = cfg_data;
                    CFG_MODE:          filter_mode = filter_mode_t'(cfg_data[0]);
                    CFG_BORDER_MARGIN: margin = cfg_data[MARGIN_BITS-1:0];
                    CFG_IMAGE_WIDTH:   width_reg = cfg_data[SIZE_BITS-1:0];
                    CFG_IMAGE_HEIGHT:  height_reg = cfg_data[SIZE_BITS-1:0];
                    default: ;
                endcase
            end
            if (pixel_valid && pixel_ready)
            begin
                if (convolve_pixel(pixel, fresh))
                    centre_results.push_back(fresh);
            end
            if (result_valid && result_ready)
            begin
                if (centre_results.size() == 0)
                begin
                    $display("%0t: result expected none, got value %0d at row %0d col %0d",
                             $time, result.result_value, result.centre_row, result.centre_col);
                    mismatches++;
                end
                else
                begin
                    want = centre_results.pop_front();
                    check_field("result_value", int'(want.result_value),
                                int'(result.result_value));
                    check_field("centre_row", int'(want.centre_row), int'(result.centre_row));
                    check_field("centre_col", int'(want.centre_col), int'(result.centre_col));
                    check_field("computed", int'(want.computed), int'(result.computed));
                    check_field("frame_last", int'(want.frame_last), int'(result.frame_last));
                end
            end
        end
        open_results <= centre_results.size();
    end

endmodule

>>> bench/window_convolution_3x3_test.sv
// Testbench top for the 3x3 window convolution: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module window_convolution_3x3_test;
    import wc3_pkg::*;

    localparam int PIXEL_TARGET  = 1150;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 80;

    logic                     clk;
    logic                     rst_n = 1'b0;
    logic                     pixel_valid = 1'b0;
    logic                     pixel_ready;
    pixel_t                   pixel = '0;
    logic                     result_valid;
    logic                     result_ready = 1'b0;
    result_t                  result;
    logic                     cfg_write_en = 1'b0;
    logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] cfg_data = '0;
    int                       open_results;
    int                       mismatches;

    int   tx_idle_pct  = 36;
    int   rx_idle_pct  = 55;
    logic hold_req     = 1'b0;
    logic hold_done    = 1'b0;
    int   hold_left    = 0;
    int   cycle_count  = 0;
    int   pixels_sent  = 0;

    window_convolution_3x3 u_top (.*);

    window_convolution_3x3_checker u_checker (.*);

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("window_convolution_3x3_test: done, errors");
            $finish;
        end
    end

    // Result side: random stalls, plus one long hold-off so that the pipeline backs up.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_ready <= 1'b0;
            hold_left    <= 0;
            hold_done    <= 1'b0;
        end
        else if (hold_req && !hold_done)
        begin
            hold_done    <= 1'b1;
            hold_left    <= HOLD_CYCLES;
            result_ready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left    <= hold_left - 1;
            result_ready <= 1'b0;
        end
        else
            result_ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_BITS-1:0] value);
        cfg_write_en <= 1'b1;
        cfg_index    <= idx;
        cfg_data     <= value;
        @(posedge clk);
    endtask

    task automatic send_pixel(input logic [PIXEL_BITS-1:0] value, input logic fs);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            pixel_valid <= 1'b0;
            @(posedge clk);
        end
        pixel_valid <= 1'b1;
        pixel       <= pixel_t'{value, fs};
        @(posedge clk);
        while (!pixel_ready)
            @(posedge clk);
        pixels_sent++;
    endtask

    // Waits for every predicted result, then lets pixels that give no result leave the pipeline.
    task automatic settle();
        pixel_valid  <= 1'b0;
        cfg_write_en <= 1'b0;
        @(posedge clk);
        while (open_results != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [PIXEL_BITS-1:0] pick_pixel();
        case ($urandom_range(7))
            0: return '0;
            1: return '1;
            default: return PIXEL_BITS'($urandom);
        endcase
    endfunction

    function automatic logic [KROW_BITS-1:0] pick_krow();
        logic [KROW_BITS-1:0] krow;
        int                   style;
        style = $urandom_range(3);
        for (int k = 0; k < 3; k++)
        begin
            case (style)
                0: krow[k*COEF_BITS +: COEF_BITS] = COEF_BITS'($urandom);
                1: krow[k*COEF_BITS +: COEF_BITS] = COEF_BITS'($urandom_range(8) - 4);
                2: krow[k*COEF_BITS +: COEF_BITS] = $urandom_range(1) ? 16'h8000 : 16'h7fff;
                default: krow[k*COEF_BITS +: COEF_BITS] = COEF_BITS'($urandom_range(4));
            endcase
        end
        return krow;
    endfunction

    initial
    begin
        int                   cur_width;
        int                   cur_height;
        int                   new_width;
        int                   phase;
        int                   phase_len;
        int                   frame_pos;
        int                   frame_size;
        logic                 fresh;
        logic                 fs;
        logic [SIZE_BITS-1:0] width_val;
        logic [SIZE_BITS-1:0] height_val;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Smallest frame, edge mode: only the centre coefficient is the most negative
        // value, so the wrapped sum lands on the one value whose magnitude is 32768.
        write_reg(CFG_IMAGE_WIDTH, CFG_DATA_BITS'(3));
        write_reg(CFG_IMAGE_HEIGHT, CFG_DATA_BITS'(3));
        write_reg(CFG_BORDER_MARGIN, CFG_DATA_BITS'(1));
        write_reg(CFG_MODE, CFG_DATA_BITS'(MODE_EDGE));
        write_reg(CFG_KERNEL_TOP, '0);
        write_reg(CFG_KERNEL_MID, {16'h0000, 16'h8000, 16'h0000});
        write_reg(CFG_KERNEL_BOTTOM, '0);
        cfg_write_en <= 1'b0;
        @(posedge clk);
        for (int i = 0; i < 9; i++)
            send_pixel(i[0] ? 16'h0000 : 16'hffff, i == 0);
        settle();

        // Blur with the largest coefficients and full-scale pixels hits the clamp.
        write_reg(CFG_MODE, CFG_DATA_BITS'(MODE_BLUR));
        write_reg(CFG_KERNEL_TOP, {3{16'h7fff}});
        write_reg(CFG_KERNEL_MID, {3{16'h7fff}});
        write_reg(CFG_KERNEL_BOTTOM, {3{16'h7fff}});
        cfg_write_en <= 1'b0;
        @(posedge clk);
        for (int i = 0; i < 9; i++)
            send_pixel(16'hffff, i == 0);
        settle();

        cur_width  = 3;
        cur_height = 3;
        frame_pos  = 0;
        phase      = 0;
        while (pixels_sent < PIXEL_TARGET)
        begin
            phase++;
            if (pixels_sent < PIXEL_TARGET / 3)
            begin
                tx_idle_pct = 36;
                rx_idle_pct = 55;
            end
            else if (pixels_sent < 2 * PIXEL_TARGET / 3)
            begin
                tx_idle_pct = 55;
                rx_idle_pct = 36;
            end
            else
            begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end

            case ($urandom_range(9))
                0: width_val = SIZE_BITS'($urandom_range(2));
                1: width_val = SIZE_BITS'($urandom_range(511, 257));
                default: width_val = SIZE_BITS'($urandom_range(12, 3));
            endcase
            case ($urandom_range(9))
                0: height_val = SIZE_BITS'($urandom_range(2));
                1: height_val = SIZE_BITS'($urandom_range(511, 257));
                default: height_val = SIZE_BITS'($urandom_range(8, 3));
            endcase
            phase_len = $urandom_range(70, 25);
            // One long phase at the widest row, three rows high.
            if (phase == 3)
            begin
                width_val  = 9'd300;
                height_val = 9'd3;
                phase_len  = 540;
            end

            new_width = cur_width;
            if (phase == 1 || phase == 3 || $urandom_range(1))
            begin
                write_reg(CFG_IMAGE_WIDTH, CFG_DATA_BITS'(width_val));
                new_width = (width_val < 3) ? 3 : (width_val > 256) ? 256 : int'(width_val);
            end
            if (phase == 1 || phase == 3 || $urandom_range(1))
            begin
                write_reg(CFG_IMAGE_HEIGHT, CFG_DATA_BITS'(height_val));
                cur_height = (height_val < 3) ? 3 : (height_val > 256) ? 256 : int'(height_val);
            end
            if (phase == 1 || $urandom_range(1))
                write_reg(CFG_MODE, CFG_DATA_BITS'($urandom_range(1)));
            if (phase == 1 || $urandom_range(1))
                write_reg(CFG_BORDER_MARGIN, CFG_DATA_BITS'($urandom_range(3)));
            if (phase == 1 || $urandom_range(1))
                write_reg(CFG_KERNEL_TOP, pick_krow());
            if (phase == 1 || $urandom_range(1))
                write_reg(CFG_KERNEL_MID, pick_krow());
            if (phase == 1 || $urandom_range(1))
                write_reg(CFG_KERNEL_BOTTOM, pick_krow());
            cfg_write_en <= 1'b0;
            if (tx_idle_pct == 0 && !hold_req)
                hold_req <= 1'b1;
            @(posedge clk);

            // A wider row would read line store columns never filled in this frame,
            // so a width increase always restarts the frame. Narrowing may happen mid-frame.
            fresh = (new_width > cur_width) || ($urandom_range(3) != 0);
            cur_width  = new_width;
            frame_size = cur_width * cur_height;
            if (fresh)
                frame_pos = 0;
            for (int i = 0; i < phase_len; i++)
            begin
                fs = (i == 0 && fresh) || (frame_pos == 0 && $urandom_range(3) != 0) ||
                     ($urandom_range(49) == 0);
                if (fs)
                    frame_pos = 0;
                send_pixel(pick_pixel(), fs);
                frame_pos = (frame_pos + 1 >= frame_size) ? 0 : frame_pos + 1;
            end
            settle();
        end

        if (mismatches == 0)
            $display("window_convolution_3x3_test: done, clean");
        else
            $display("window_convolution_3x3_test: done, errors");
        $finish;
    end

endmodule
